/* rtl/stq_pkg.sv */
// stq_pkg: shared types and constants for the stepper block queue
// depends on nothing
`timescale 1ns / 1ps
package stq_pkg;
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned TpmW = 28;
  localparam int unsigned SpdW = 24;
  localparam int unsigned PosW = 31;
  localparam int unsigned TimeW = 32;
  localparam int unsigned TagW = 8;
  localparam int unsigned EntryW = SpdW + TpmW + 1 + 3 * PosW + TagW;
  localparam logic [TpmW-1:0] TpmReset = 28'd160980000;
  localparam logic [SpdW-1:0] SpeedMax = {SpdW{1'b1}};
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam logic OpTick = 1'b0;
  localparam logic OpPush = 1'b1;

  typedef struct packed {
    logic [SpdW-1:0] start_spd;
    logic [TpmW-1:0] acc_ticks;
    logic            dir;
    logic [PosW-1:0] end_pos;
    logic [PosW-1:0] accel_until;
    logic [PosW-1:0] decel_after;
    logic [TagW-1:0] tag;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic       take_in;
    logic       div_start;
    logic [1:0] div_sel;
    logic       push_write;
    logic       tick_eval;
    logic       tick_apply;
    logic       tick_step;
    logic       out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic is_push;
    logic full;
    logic empty;
    logic need_speed;
  } sts_t;

  localparam logic [1:0] DivAccel = 2'd0;
  localparam logic [1:0] DivSpeed = 2'd1;
endpackage

/* rtl/stq_ram.sv */
// stq_ram: generic single-port-write ram with registered read
// depends on nothing
`timescale 1ns / 1ps
module stq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/stq_div.sv */
// stq_div: restoring serial divider, one quotient bit per cycle
// depends on stq_pkg
`timescale 1ns / 1ps
module stq_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [stq_pkg::TpmW-1:0]  dividend_i,
  input  logic [stq_pkg::SpdW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [stq_pkg::TpmW-1:0]  quot_o
);
  import stq_pkg::*;
  localparam int unsigned CntW = $clog2(TpmW + 1);
  logic [CntW-1:0] cnt_q;
  logic [TpmW-1:0] quot_q;
  logic [SpdW:0]   rem_q;
  logic [SpdW-1:0] dsr_q;
  logic [SpdW:0]   trial;
  logic [SpdW:0]   diff;

  assign trial = {rem_q[SpdW-1:0], quot_q[TpmW-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(TpmW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      if (!diff[SpdW]) begin
        rem_q  <= diff;
        quot_q <= {quot_q[TpmW-2:0], 1'b1};
      end else begin
        rem_q  <= trial;
        quot_q <= {quot_q[TpmW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
endmodule

/* rtl/stq_datapath.sv */
// stq_datapath: ring storage, motion registers, divider and result word
// depends on stq_pkg, stq_ram, stq_div
`timescale 1ns / 1ps
module stq_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  stq_pkg::cmd_t            cmd_i,
  output stq_pkg::sts_t            sts_o,
  input  logic [stq_pkg::TpmW-1:0] tpm_i,
  input  logic                     operation_i,
  input  logic signed [31:0]       step_count_i,
  input  logic [stq_pkg::SpdW-1:0] start_speed_i,
  input  logic [stq_pkg::SpdW-1:0] accel_rate_i,
  input  logic [stq_pkg::PosW-1:0] accel_length_i,
  input  logic [stq_pkg::PosW-1:0] decel_start_i,
  input  logic [stq_pkg::TagW-1:0] block_tag_i,
  output logic                     step_level_o,
  output logic                     direction_o,
  output logic                     stepped_o,
  output logic                     block_done_o,
  output logic [stq_pkg::TagW-1:0] done_tag_o,
  output logic                     push_accepted_o,
  output logic [stq_pkg::SpdW-1:0] current_speed_o
);
  import stq_pkg::*;

  logic            op_q;
  logic [31:0]     cnt_in_q;
  logic [SpdW-1:0] es_in_q, ar_in_q;
  logic [PosW-1:0] al_in_q, ds_in_q;
  logic [TagW-1:0] tag_in_q;

  logic [IdxW-1:0]  head_q, tail_q;
  logic [QueueDepth-1:0] fresh_q;
  logic [SpdW-1:0]  speed_q;
  logic [TpmW-1:0]  period_q;
  logic [TimeW-1:0] time_q, prev_step_q, prev_acc_q;
  logic [PosW-1:0]  pos_q;
  logic             pulse_q, dir_pin_q;

  logic            stepped_q, done_q, acc_q;
  logic [TagW-1:0] dtag_q;

  logic [IdxW-1:0] head_nx;
  logic            full, empty;
  entry_t          wentry, rentry;
  logic [31:0]     mag32;
  logic [PosW-1:0] mag;

  logic            div_busy;
  logic [TpmW-1:0] quot;
  logic [SpdW-1:0] div_dsr;

  // tick evaluation
  logic            active_q, chg_q;
  logic [SpdW-1:0] new_spd_q;
  logic [SpdW-1:0] spd_base;
  logic [TimeW-1:0] el_acc;
  logic            eval_chg;
  logic [SpdW-1:0] eval_spd;
  logic            need_speed_q;

  function automatic logic [IdxW-1:0] inc_idx(input logic [IdxW-1:0] i);
    inc_idx = (32'(i) == QueueDepth - 1) ? '0 : i + 1'b1;
  endfunction

  assign head_nx = inc_idx(head_q);
  assign full    = (head_nx == tail_q);
  assign empty   = (head_q == tail_q);

  assign mag32 = step_count_i[31] ? (~step_count_i + 32'd1) : step_count_i;
  always_comb begin
    mag = mag32[PosW-1:0];
    if (step_count_i[31] && mag32[31]) mag = PosMax;
  end

  always_comb begin
    wentry.start_spd    = (es_in_q == '0) ? SpdW'(1) : es_in_q;
    wentry.acc_ticks    = quot;
    wentry.dir          = !cnt_in_q[31];
    wentry.end_pos      = cnt_in_q[PosW-1:0];
    wentry.accel_until  = al_in_q;
    wentry.decel_after  = ds_in_q;
    wentry.tag          = tag_in_q;
  end

  stq_ram #(.Width(EntryW), .Depth(QueueDepth)) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push_write),
    .waddr_i (head_q),
    .wdata_i (wentry),
    .raddr_i (tail_q),
    .rdata_o (rentry)
  );

  assign div_dsr = (cmd_i.div_sel == DivAccel) ?
                   ((ar_in_q == '0) ? SpdW'(1) : ar_in_q) :
                   ((new_spd_q == '0) ? SpdW'(1) : new_spd_q);

  stq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (tpm_i),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign spd_base = fresh_q[tail_q] ? rentry.start_spd : speed_q;
  assign el_acc   = time_q - prev_acc_q;

  always_comb begin
    eval_chg = 1'b0;
    eval_spd = spd_base;
    if (pos_q < rentry.accel_until) begin
      if (el_acc > 32'(rentry.acc_ticks)) begin
        eval_chg = 1'b1;
        eval_spd = (spd_base < SpeedMax) ? spd_base + 1'b1 : spd_base;
      end
    end else if (pos_q > rentry.decel_after) begin
      if (el_acc > 32'(rentry.acc_ticks)) begin
        eval_chg = 1'b1;
        eval_spd = (spd_base > SpdW'(1)) ? spd_base - 1'b1 : SpdW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      op_q     <= operation_i;
      cnt_in_q <= {step_count_i[31], mag};
      es_in_q  <= start_speed_i;
      ar_in_q  <= accel_rate_i;
      al_in_q  <= accel_length_i;
      ds_in_q  <= decel_start_i;
      tag_in_q <= block_tag_i;
    end
    if (cmd_i.tick_eval) begin
      active_q  <= rentry.end_pos > pos_q;
      chg_q     <= eval_chg;
      new_spd_q <= eval_spd;
    end
    if (cmd_i.out_load) begin
      done_tag_o <= dtag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; tail_q <= '0; fresh_q <= '0;
      speed_q <= '0; period_q <= '0; time_q <= '0;
      prev_step_q <= '0; prev_acc_q <= '0; pos_q <= '0;
      pulse_q <= 1'b0; dir_pin_q <= 1'b0;
      stepped_q <= 1'b0; done_q <= 1'b0; acc_q <= 1'b0; dtag_q <= '0;
      step_level_o <= 1'b0; direction_o <= 1'b0; stepped_o <= 1'b0;
      block_done_o <= 1'b0; push_accepted_o <= 1'b0; current_speed_o <= '0;
    end else begin
      if (cmd_i.take_in) begin
        stepped_q <= 1'b0; done_q <= 1'b0; acc_q <= 1'b0; dtag_q <= '0;
        if (operation_i == OpTick) time_q <= time_q + 1'b1;
      end
      if (cmd_i.push_write) begin
        fresh_q[head_q] <= 1'b1;
        head_q <= head_nx;
        acc_q  <= 1'b1;
      end
      if (cmd_i.tick_apply) begin
        if (!active_q) begin
          done_q <= 1'b1;
          dtag_q <= rentry.tag;
          tail_q <= inc_idx(tail_q);
          pos_q  <= '0;
        end else begin
          if (fresh_q[tail_q]) begin
            dir_pin_q <= rentry.dir;
            fresh_q[tail_q] <= 1'b0;
          end
          speed_q <= new_spd_q;
          if (chg_q) prev_acc_q <= time_q;
        end
      end
      if (cmd_i.tick_step && active_q) begin
        if (need_speed_q) period_q <= quot;
        if (time_q - prev_step_q >= 32'(need_speed_q ? quot : period_q)) begin
          pulse_q     <= ~pulse_q;
          pos_q       <= pos_q + 1'b1;
          prev_step_q <= time_q;
          stepped_q   <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        step_level_o    <= pulse_q;
        direction_o     <= dir_pin_q;
        stepped_o       <= stepped_q;
        block_done_o    <= done_q;
        push_accepted_o <= acc_q;
        current_speed_o <= speed_q;
      end
    end
  end

  // need_speed latched during apply so step phase sees it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_speed_q <= 1'b0;
    end else if (cmd_i.tick_apply) begin
      need_speed_q <= active_q && (chg_q || fresh_q[tail_q]);
    end
  end

  assign sts_o.div_busy   = div_busy;
  assign sts_o.is_push    = op_q;
  assign sts_o.full       = full;
  assign sts_o.empty      = empty;
  assign sts_o.need_speed = need_speed_q;
endmodule

/* rtl/stq_ctrl.sv */
// stq_ctrl: sequencer for push and tick words
// depends on stq_pkg
`timescale 1ns / 1ps
module stq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  stq_pkg::sts_t sts_i,
  output stq_pkg::cmd_t cmd_o
);
  import stq_pkg::*;
  typedef enum logic [3:0] {
    StIdle, StPushDiv, StPushWait, StTickRd, StTickEval, StTickApply,
    StTickDiv, StTickWait, StTickStep, StOut
  } state_e;
  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.take_in = accept;
    cmd_o.div_sel = DivAccel;
    case (state_q)
      StPushDiv: begin
        cmd_o.div_start = !sts_i.full;
      end
      StPushWait: begin
        cmd_o.push_write = !sts_i.div_busy;
      end
      StTickEval:  cmd_o.tick_eval = 1'b1;
      StTickApply: cmd_o.tick_apply = 1'b1;
      StTickDiv: begin
        cmd_o.div_sel   = DivSpeed;
        cmd_o.div_start = sts_i.need_speed;
      end
      StTickStep: cmd_o.tick_step = 1'b1;
      StOut:      cmd_o.out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_o.out_load || (out_valid_q && out_stall_i);
      case (state_q)
        StIdle: begin
          if (accept) state_q <= StTickRd;
        end
        StTickRd: begin
          if (sts_i.is_push) state_q <= StPushDiv;
          else if (sts_i.empty) state_q <= StOut;
          else state_q <= StTickEval;
        end
        StPushDiv: begin
          state_q <= sts_i.full ? StOut : StPushWait;
        end
        StPushWait: begin
          if (!sts_i.div_busy) state_q <= StOut;
        end
        StTickEval:  state_q <= StTickApply;
        StTickApply: state_q <= StTickDiv;
        StTickDiv:   state_q <= StTickWait;
        StTickWait: begin
          if (!sts_i.div_busy) state_q <= StTickStep;
        end
        StTickStep: state_q <= StOut;
        StOut: begin
          if (cmd_o.out_load) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push_write |-> !sts_i.full)
    else $error("push written into full ring");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o)
    else $error("result load lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StTickRd)
    else $error("accepted word not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick_step |-> !sts_i.div_busy)
    else $error("step taken while divider busy");
endmodule

/* rtl/stepper_trapezoid_block_queue_unit.sv */
// channel | valid        | stall        | payload
// in      | in_valid_i   | in_stall_o   | operation_i .. block_tag_i
// out     | out_valid_o  | out_stall_i  | step_level_o .. current_speed_o
// cfg     | psel/penable | pready=1     | paddr/pwdata, reg 0 at 0x0
// a push runs the serial divider for its accel period; a refused push (full ring) skips it
// a tick runs eval, apply, a speed divide when speed changes or a block starts, then step
// a tick on an empty ring goes straight to output; one word is in flight at a time
// reset clears ring pointers and motion state; ring ram holds no reset
// a stalled result holds the sequencer in its output state
// top level: depends on stq_pkg, stq_ctrl, stq_datapath
`timescale 1ns / 1ps
module stepper_trapezoid_block_queue_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     operation_i,
  input  logic signed [31:0]       step_count_i,
  input  logic [stq_pkg::SpdW-1:0] start_speed_i,
  input  logic [stq_pkg::SpdW-1:0] accel_rate_i,
  input  logic [stq_pkg::PosW-1:0] accel_length_i,
  input  logic [stq_pkg::PosW-1:0] decel_start_i,
  input  logic [stq_pkg::TagW-1:0] block_tag_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     step_level_o,
  output logic                     direction_o,
  output logic                     stepped_o,
  output logic                     block_done_o,
  output logic [stq_pkg::TagW-1:0] done_tag_o,
  output logic                     push_accepted_o,
  output logic [stq_pkg::SpdW-1:0] current_speed_o
);
  import stq_pkg::*;
  localparam logic RegTpm = 1'b0;
  logic [TpmW-1:0] tpm_q;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == RegTpm) ? 32'(tpm_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q <= TpmReset;
    end else if (psel && penable && pwrite && paddr == RegTpm) begin
      tpm_q <= pwdata[TpmW-1:0];
    end
  end

  stq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  stq_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .tpm_i           (tpm_q),
    .operation_i     (operation_i),
    .step_count_i    (step_count_i),
    .start_speed_i   (start_speed_i),
    .accel_rate_i    (accel_rate_i),
    .accel_length_i  (accel_length_i),
    .decel_start_i   (decel_start_i),
    .block_tag_i     (block_tag_i),
    .step_level_o    (step_level_o),
    .direction_o     (direction_o),
    .stepped_o       (stepped_o),
    .block_done_o    (block_done_o),
    .done_tag_o      (done_tag_o),
    .push_accepted_o (push_accepted_o),
    .current_speed_o (current_speed_o)
  );
endmodule

/* test/stepper_trapezoid_block_queue_unit_test.sv */
// stepper_trapezoid_block_queue_unit_test: random and directed test of the stepper block queue
// a scoreboard class predicts every result word from the accepted input words
// depends on stq_pkg and stepper_trapezoid_block_queue_unit
`timescale 1ns / 1ps
module stepper_trapezoid_block_queue_unit_test;
  import stq_pkg::*;

  typedef struct {
    logic                     op;
    logic signed [31:0]       steps;
    logic [SpdW-1:0]          entry;
    logic [SpdW-1:0]          accel;
    logic [PosW-1:0]          accel_len;
    logic [PosW-1:0]          decel_at;
    logic [TagW-1:0]          tag;
  } move_word_t;

  typedef struct {
    logic            step_level;
    logic            direction;
    logic            stepped;
    logic            done;
    logic [TagW-1:0] done_tag;
    logic            accepted;
    logic [SpdW-1:0] speed;
  } pin_word_t;

  class motion_scoreboard;
    logic [SpdW-1:0]  q_entry [QueueDepth];
    logic [TpmW-1:0]  q_accel_per [QueueDepth];
    logic             q_dir [QueueDepth];
    logic [PosW-1:0]  q_end [QueueDepth];
    logic [PosW-1:0]  q_accel_until [QueueDepth];
    logic [PosW-1:0]  q_decel_after [QueueDepth];
    logic             q_fresh [QueueDepth];
    logic [TagW-1:0]  q_tag [QueueDepth];
    logic [IdxW-1:0]  head, tail;
    logic [SpdW-1:0]  speed;
    logic [TpmW-1:0]  period;
    logic [TimeW-1:0] clock_count, prev_step_tick, prev_accel_tick;
    logic [PosW-1:0]  pos;
    logic             pulse_level, dir_pin;
    logic [TpmW-1:0]  tpm;
    pin_word_t        pending_words[$];
    int               fails;

    function new();
      head = '0; tail = '0; speed = '0; period = '0;
      clock_count = '0; prev_step_tick = '0; prev_accel_tick = '0;
      pos = '0; pulse_level = 1'b0; dir_pin = 1'b0; tpm = TpmReset; fails = 0;
    endfunction

    function logic [TpmW-1:0] ticks_over(logic [SpdW-1:0] d);
      logic [31:0] dd;
      dd = (d == 0) ? 32'd1 : 32'(d);
      return TpmW'(32'(tpm) / dd);
    endfunction

    function void note(move_word_t w);
      pin_word_t r;
      logic [31:0] raw, mag;
      logic [IdxW-1:0] nh, t;
      r = '{default: 0};
      if (w.op == OpPush) begin
        nh = head + 1'b1;
        if (nh != tail) begin
          raw = w.steps;
          if (raw[31]) begin
            mag = -raw;
            if (mag > 32'(PosMax)) mag = 32'(PosMax);
            q_dir[head] = 1'b0;
          end else begin
            mag = raw;
            q_dir[head] = 1'b1;
          end
          q_entry[head] = (w.entry == 0) ? SpdW'(1) : w.entry;
          q_accel_per[head] = ticks_over(w.accel);
          q_end[head] = mag[PosW-1:0];
          q_accel_until[head] = w.accel_len;
          q_decel_after[head] = w.decel_at;
          q_tag[head] = w.tag;
          q_fresh[head] = 1'b1;
          head = nh;
          r.accepted = 1'b1;
        end
      end else begin
        clock_count++;
        if (head != tail) begin
          t = tail;
          if (q_end[t] > pos) begin
            if (q_fresh[t]) begin
              speed = q_entry[t];
              period = ticks_over(speed);
              dir_pin = q_dir[t];
              q_fresh[t] = 1'b0;
            end
            if (pos < q_accel_until[t]) begin
              if (clock_count - prev_accel_tick > 32'(q_accel_per[t])) begin
                if (speed < SpeedMax) speed++;
                period = ticks_over(speed);
                prev_accel_tick = clock_count;
              end
            end else if (pos > q_decel_after[t]) begin
              if (clock_count - prev_accel_tick > 32'(q_accel_per[t])) begin
                if (speed > 1) speed--;
                else speed = SpdW'(1);
                period = ticks_over(speed);
                prev_accel_tick = clock_count;
              end
            end
            if (clock_count - prev_step_tick >= 32'(period)) begin
              pulse_level ^= 1'b1;
              pos++;
              prev_step_tick = clock_count;
              r.stepped = 1'b1;
            end
          end else begin
            r.done = 1'b1;
            r.done_tag = q_tag[t];
            tail = t + 1'b1;
            pos = '0;
          end
        end
      end
      r.step_level = pulse_level;
      r.direction = dir_pin;
      r.speed = speed;
      pending_words.push_back(r);
    endfunction

    function void field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        fails++;
      end
    endfunction

    function void check(pin_word_t a);
      pin_word_t e;
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
        return;
      end
      e = pending_words.pop_front();
      field("step_level", 32'(e.step_level), 32'(a.step_level));
      field("direction", 32'(e.direction), 32'(a.direction));
      field("stepped", 32'(e.stepped), 32'(a.stepped));
      field("block_done", 32'(e.done), 32'(a.done));
      field("done_tag", 32'(e.done_tag), 32'(a.done_tag));
      field("push_accepted", 32'(e.accepted), 32'(a.accepted));
      field("current_speed", 32'(e.speed), 32'(a.speed));
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0, paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic operation_i = 0;
  logic signed [31:0] step_count_i = 0;
  logic [SpdW-1:0] start_speed_i = 0, accel_rate_i = 0;
  logic [PosW-1:0] accel_length_i = 0, decel_start_i = 0;
  logic [TagW-1:0] block_tag_i = 0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic step_level_o, direction_o, stepped_o, block_done_o, push_accepted_o;
  logic [TagW-1:0] done_tag_o;
  logic [SpdW-1:0] current_speed_o;

  motion_scoreboard board = new();
  int max_wait = 5;
  int out_wait = 0;

  always #1 clk_i = ~clk_i;

  stepper_trapezoid_block_queue_unit dut (.*);

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      board.check('{step_level_o, direction_o, stepped_o, block_done_o, done_tag_o,
                    push_accepted_o, current_speed_o});
      out_wait = $urandom_range(0, max_wait);
    end else if (out_valid_o && out_wait > 0) begin
      out_wait--;
    end
    out_stall_i <= (out_wait > 0);
  end

  task automatic send(move_word_t w);
    int gap;
    gap = $urandom_range(0, max_wait);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    operation_i <= w.op;
    step_count_i <= w.steps;
    start_speed_i <= w.entry;
    accel_rate_i <= w.accel;
    accel_length_i <= w.accel_len;
    decel_start_i <= w.decel_at;
    block_tag_i <= w.tag;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note(w);
  endtask

  task automatic tick();
    move_word_t w;
    w = '{OpTick, $signed(32'($urandom)), SpdW'($urandom), SpdW'($urandom),
          PosW'($urandom), PosW'($urandom), TagW'($urandom)};
    send(w);
  endtask

  task automatic push(logic signed [31:0] s, logic [SpdW-1:0] e, logic [SpdW-1:0] a,
                      logic [PosW-1:0] al, logic [PosW-1:0] ds, logic [TagW-1:0] t);
    send('{OpPush, s, e, a, al, ds, t});
  endtask

  task automatic set_tpm(logic [TpmW-1:0] v);
    in_valid_i <= 0;
    while (board.pending_words.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 1'b0; pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.tpm = v;
  endtask

  task automatic random_phase(int count, bit fast_entry);
    logic signed [31:0] s;
    logic [SpdW-1:0] e;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) max_wait = ($urandom_range(0, 3) == 0) ? 0 : 5;
      if ($urandom_range(0, 3) == 0) begin
        s = $signed(32'($urandom_range(0, 6)));
        if ($urandom_range(0, 1)) s = -s;
        e = fast_entry ? SpdW'($urandom_range(1 << 23, (1 << 24) - 1))
                       : SpdW'($urandom_range(0, (1 << 24) - 1));
        push(s, e, SpdW'($urandom_range(0, (1 << 24) - 1)), PosW'($urandom),
             PosW'($urandom), TagW'($urandom));
      end else begin
        tick();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: clamps, sign extremes, zero length, full ring
    set_tpm(28'd1);
    push(32'sd3, 24'd0, 24'd0, 31'd2, 31'd0, 8'd0);
    push(-32'sd2, SpeedMax, SpeedMax, PosMax, PosMax, 8'hff);
    push(32'sd0, 24'd1, 24'd1, 31'd0, 31'd0, 8'd7);
    push(32'sd1, 24'd5, 24'd3, 31'd0, 31'd0, 8'd8);
    push(32'sd6, SpeedMax, SpeedMax, PosMax, 31'd0, 8'd9);
    push(-32'sd1, 24'd2, 24'd2, 31'd1, 31'd0, 8'd10);
    push(32'sd4, 24'd9, 24'd1, 31'd0, 31'd1, 8'd11);
    push(32'sd2, 24'd3, 24'd3, 31'd1, 31'd1, 8'd12);
    repeat (14) tick();

    random_phase(250, 0);
    set_tpm({TpmW{1'b1}});
    random_phase(250, 1);
    set_tpm(TpmW'($urandom_range(2, 64)));
    random_phase(250, 0);
    set_tpm(TpmReset);
    random_phase(250, 1);

    // most negative count saturates its length
    push(32'sh8000_0000, SpeedMax, 24'd1, 31'd0, 31'd0, 8'h5a);
    repeat (4) tick();
    in_valid_i <= 0;

    while (board.pending_words.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end
endmodule
